[sv/nva_pkg.sv]
`timescale 1ns / 1ps

package nva_pkg;

  // pool size and derived widths
  localparam int unsigned VOICE_COUNT = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned IDX_W       = $clog2(VOICE_COUNT);
  localparam int unsigned CNT_W       = $clog2(VOICE_COUNT + 1);
  localparam int unsigned SRC_W       = CNT_W + 1;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned VOICE_W     = 3;

  // releases per tick are bounded by the pool and by the result limit
  localparam int unsigned REL_LIMIT =
    (VOICE_COUNT < MAX_RESULTS) ? VOICE_COUNT : MAX_RESULTS;

  typedef logic [IDX_W-1:0] voice_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam count_t VOICE_COUNT_C = CNT_W'(VOICE_COUNT);
  localparam count_t REL_LIMIT_C   = CNT_W'(REL_LIMIT);

  // pan gate bits
  localparam logic [7:0] PAN_OFF_MASK = 8'hFE;
  localparam logic [7:0] PAN_ON_BIT   = 8'h01;

  // operation codes
  localparam logic OP_PLAY = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAY_START,
    ST_PLAY_SEARCH,
    ST_PLAY_INSERT,
    ST_EMIT_ON,
    ST_EMIT_ERR,
    ST_TICK_RETURN,
    ST_TICK_RELEASE,
    ST_TICK_COMPACT,
    ST_TICK_DEC
  } state_t;

  // one result transfer
  typedef struct packed {
    logic [VOICE_W-1:0] voice_index;
    logic               gate_on;
    logic [15:0]        out_pitch;
    logic [15:0]        out_duty;
    logic [7:0]         out_attack;
    logic [7:0]         out_decay;
    logic [7:0]         out_wave;
    logic [7:0]         pan_gate_byte;
    logic               no_voice_error;
    logic               last_of_run;
  } result_t;

  // shared compare and decrement unit outputs
  typedef struct packed {
    logic             longer;
    logic             expired;
    logic [LEN_W-1:0] dec_value;
  } alu_res_t;

endpackage

[sv/nva_if.sv]
`timescale 1ns / 1ps

// request channel: note or tick
interface nva_req_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [15:0]       note_length;
  logic [15:0]       pitch_value;
  logic [15:0]       duty_value;
  logic [7:0]        attack_volume;
  logic [7:0]        decay_volume;
  logic [7:0]        wave_and_release;
  logic signed [7:0] stereo_pan;

  modport source (
    output valid, operation, note_length, pitch_value, duty_value,
           attack_volume, decay_volume, wave_and_release, stereo_pan,
    input  ready
  );
  modport sink (
    input  valid, operation, note_length, pitch_value, duty_value,
           attack_volume, decay_volume, wave_and_release, stereo_pan,
    output ready
  );
endinterface

// result channel: voice register writes
interface nva_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  voice_index;
  logic        gate_on;
  logic [15:0] out_pitch;
  logic [15:0] out_duty;
  logic [7:0]  out_attack;
  logic [7:0]  out_decay;
  logic [7:0]  out_wave;
  logic [7:0]  pan_gate_byte;
  logic        no_voice_error;
  logic        last_of_run;

  modport source (
    output valid, voice_index, gate_on, out_pitch, out_duty, out_attack,
           out_decay, out_wave, pan_gate_byte, no_voice_error, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, voice_index, gate_on, out_pitch, out_duty, out_attack,
           out_decay, out_wave, pan_gate_byte, no_voice_error, last_of_run,
    output ready
  );
endinterface

[sv/nva_alu.sv]
`timescale 1ns / 1ps

module nva_alu (
  input  logic [nva_pkg::LEN_W-1:0] remaining,
  input  logic [nva_pkg::LEN_W-1:0] length,
  output nva_pkg::alu_res_t         res
);

  // compare against the new note, test for expiry, saturating decrement
  always_comb begin
    res.longer    = length > remaining;
    res.expired   = remaining <= nva_pkg::LEN_W'(1);
    res.dec_value = (remaining != '0) ? remaining - nva_pkg::LEN_W'(1) : '0;
  end

endmodule

[sv/nva_outreg.sv]
`timescale 1ns / 1ps

module nva_outreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  nva_pkg::result_t data,
  output logic             slot_free,
  nva_rsp_if.source        rsp
);

  nva_pkg::result_t hold;

  assign slot_free = !rsp.valid || rsp.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= data;
    end
  end

  assign rsp.voice_index    = hold.voice_index;
  assign rsp.gate_on        = hold.gate_on;
  assign rsp.out_pitch      = hold.out_pitch;
  assign rsp.out_duty       = hold.out_duty;
  assign rsp.out_attack     = hold.out_attack;
  assign rsp.out_decay      = hold.out_decay;
  assign rsp.out_wave       = hold.out_wave;
  assign rsp.pan_gate_byte  = hold.pan_gate_byte;
  assign rsp.no_voice_error = hold.no_voice_error;
  assign rsp.last_of_run    = hold.last_of_run;

endmodule

[sv/note_voice_allocator.sv]
`timescale 1ns / 1ps
// play: pop a free voice, search past shorter playing voices, insert, emit result
// refused play: error result; tick: return releases, release expired, compact,
// count down the voices left; one item at a time, plus stalls on a full result
// the single compare/decrement unit walks the playing list
// result register lets the next item start while the last result waits
// reset: synchronous; free stack reloads 0..7 with 0 on top and eight free

module note_voice_allocator (
  input  logic       clk,
  input  logic       rst,
  nva_req_if.sink    req,
  nva_rsp_if.source  rsp
);

  nva_pkg::state_t state, state_next;

  // latched request payload
  logic [nva_pkg::LEN_W-1:0] len_r;
  logic [15:0] pitch_r, duty_r;
  logic [7:0]  att_r, dec_r, wave_r, pan_r;

  // voice stores
  logic [nva_pkg::LEN_W-1:0] rem [nva_pkg::VOICE_COUNT];
  logic [nva_pkg::LEN_W-1:0] rem_next [nva_pkg::VOICE_COUNT];
  logic [7:0]                vpan [nva_pkg::VOICE_COUNT];
  logic [7:0]                vpan_next [nva_pkg::VOICE_COUNT];
  nva_pkg::voice_t           order [nva_pkg::VOICE_COUNT];
  nva_pkg::voice_t           order_next [nva_pkg::VOICE_COUNT];
  nva_pkg::voice_t           free_stack [nva_pkg::VOICE_COUNT];
  nva_pkg::voice_t           free_stack_next [nva_pkg::VOICE_COUNT];
  nva_pkg::voice_t           rel_stack [nva_pkg::VOICE_COUNT];
  nva_pkg::voice_t           rel_stack_next [nva_pkg::VOICE_COUNT];

  nva_pkg::count_t fc, fc_next, pc, pc_next, rc, rc_next;
  nva_pkg::count_t pos, pos_next, head, head_next, idx, idx_next;
  nva_pkg::voice_t cur_voice, cur_voice_next, pend_voice, pend_voice_next;
  logic            have_pend, have_pend_next;

  nva_pkg::voice_t   rd_voice;
  nva_pkg::voice_t   fc_top;
  nva_pkg::alu_res_t alu;
  nva_pkg::result_t  res;
  logic              out_load, slot_free;
  logic              accept;

  assign req.ready = (state == nva_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign fc_top    = fc[nva_pkg::IDX_W-1:0] - nva_pkg::IDX_W'(1);

  // read address of the shared unit
  always_comb begin
    case (state)
      nva_pkg::ST_PLAY_SEARCH:  rd_voice = order[pos[nva_pkg::IDX_W-1:0]];
      nva_pkg::ST_TICK_RELEASE: rd_voice = order[head[nva_pkg::IDX_W-1:0]];
      nva_pkg::ST_TICK_DEC:     rd_voice = order[idx[nva_pkg::IDX_W-1:0]];
      default:                  rd_voice = order[0];
    endcase
  end

  nva_alu u_alu (
    .remaining (rem[rd_voice]),
    .length    (len_r),
    .res       (alu)
  );

  nva_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .data      (res),
    .slot_free (slot_free),
    .rsp       (rsp)
  );

  // sequencer
  always_comb begin
    logic [nva_pkg::SRC_W-1:0] src;
    src             = '0;
    state_next      = state;
    rem_next        = rem;
    vpan_next       = vpan;
    order_next      = order;
    free_stack_next = free_stack;
    rel_stack_next  = rel_stack;
    fc_next         = fc;
    pc_next         = pc;
    rc_next         = rc;
    pos_next        = pos;
    head_next       = head;
    idx_next        = idx;
    cur_voice_next  = cur_voice;
    pend_voice_next = pend_voice;
    have_pend_next  = have_pend;
    out_load        = 1'b0;
    res             = '0;

    case (state)
      nva_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (req.operation == nva_pkg::OP_PLAY) ?
                       nva_pkg::ST_PLAY_START : nva_pkg::ST_TICK_RETURN;
        end
      end

      // pop a free voice and store its length and pan, or go to the error result if none
      nva_pkg::ST_PLAY_START: begin
        if (fc == '0 || pc >= nva_pkg::VOICE_COUNT_C) begin
          state_next = nva_pkg::ST_EMIT_ERR;
        end else begin
          fc_next                      = fc - nva_pkg::CNT_W'(1);
          cur_voice_next               = free_stack[fc_top];
          rem_next[free_stack[fc_top]]  = len_r;
          vpan_next[free_stack[fc_top]] = pan_r;
          pos_next                     = '0;
          state_next                   = nva_pkg::ST_PLAY_SEARCH;
        end
      end

      // find the first entry with equal or longer remaining time
      nva_pkg::ST_PLAY_SEARCH: begin
        if (pos < pc && alu.longer) begin
          pos_next = pos + nva_pkg::CNT_W'(1);
        end else begin
          state_next = nva_pkg::ST_PLAY_INSERT;
        end
      end

      // open a gap at pos and drop the voice in
      nva_pkg::ST_PLAY_INSERT: begin
        for (int i = 0; i < nva_pkg::VOICE_COUNT; i++) begin
          if (nva_pkg::CNT_W'(i) > pos && nva_pkg::CNT_W'(i) <= pc) begin
            order_next[i] = order[nva_pkg::IDX_W'(i - 1)];
          end
          if (nva_pkg::CNT_W'(i) == pos) begin
            order_next[i] = cur_voice;
          end
        end
        pc_next    = pc + nva_pkg::CNT_W'(1);
        state_next = nva_pkg::ST_EMIT_ON;
      end

      nva_pkg::ST_EMIT_ON: begin
        if (slot_free) begin
          out_load          = 1'b1;
          res.voice_index   = nva_pkg::VOICE_W'(cur_voice);
          res.gate_on       = 1'b1;
          res.out_pitch     = pitch_r;
          res.out_duty      = duty_r;
          res.out_attack    = att_r;
          res.out_decay     = dec_r;
          res.out_wave      = wave_r;
          res.pan_gate_byte = pan_r | nva_pkg::PAN_ON_BIT;
          res.last_of_run   = 1'b1;
          state_next        = nva_pkg::ST_IDLE;
        end
      end

      nva_pkg::ST_EMIT_ERR: begin
        if (slot_free) begin
          out_load           = 1'b1;
          res.no_voice_error = 1'b1;
          res.last_of_run    = 1'b1;
          state_next         = nva_pkg::ST_IDLE;
        end
      end

      // move last tick's releases back, most recent first
      nva_pkg::ST_TICK_RETURN: begin
        if (rc != '0 && fc < nva_pkg::VOICE_COUNT_C) begin
          free_stack_next[fc[nva_pkg::IDX_W-1:0]] =
            rel_stack[rc[nva_pkg::IDX_W-1:0] - nva_pkg::IDX_W'(1)];
          fc_next = fc + nva_pkg::CNT_W'(1);
          rc_next = rc - nva_pkg::CNT_W'(1);
        end else begin
          rc_next        = '0;
          head_next      = '0;
          have_pend_next = 1'b0;
          state_next     = nva_pkg::ST_TICK_RELEASE;
        end
      end

      // release expired voices from the head; one result held back to mark the last
      nva_pkg::ST_TICK_RELEASE: begin
        if (head < pc && head < nva_pkg::REL_LIMIT_C && alu.expired) begin
          if (!have_pend || slot_free) begin
            if (have_pend) begin
              out_load          = 1'b1;
              res.voice_index   = nva_pkg::VOICE_W'(pend_voice);
              res.pan_gate_byte = vpan[pend_voice] & nva_pkg::PAN_OFF_MASK;
            end
            pend_voice_next = rd_voice;
            have_pend_next  = 1'b1;
            if (rc < nva_pkg::VOICE_COUNT_C) begin
              rel_stack_next[rc[nva_pkg::IDX_W-1:0]] = rd_voice;
              rc_next = rc + nva_pkg::CNT_W'(1);
            end
            head_next = head + nva_pkg::CNT_W'(1);
          end
        end else if (!have_pend) begin
          state_next = nva_pkg::ST_TICK_COMPACT;
        end else if (slot_free) begin
          out_load          = 1'b1;
          res.voice_index   = nva_pkg::VOICE_W'(pend_voice);
          res.pan_gate_byte = vpan[pend_voice] & nva_pkg::PAN_OFF_MASK;
          res.last_of_run   = 1'b1;
          have_pend_next    = 1'b0;
          state_next        = nva_pkg::ST_TICK_COMPACT;
        end
      end

      // drop the released entries off the head of the list
      nva_pkg::ST_TICK_COMPACT: begin
        for (int i = 0; i < nva_pkg::VOICE_COUNT; i++) begin
          src = nva_pkg::SRC_W'(i) + nva_pkg::SRC_W'(head);
          if (src < nva_pkg::SRC_W'(nva_pkg::VOICE_COUNT)) begin
            order_next[i] = order[src[nva_pkg::IDX_W-1:0]];
          end
        end
        pc_next    = pc - head;
        idx_next   = '0;
        state_next = nva_pkg::ST_TICK_DEC;
      end

      // count down each playing voice, one per cycle
      nva_pkg::ST_TICK_DEC: begin
        if (idx < pc) begin
          rem_next[rd_voice] = alu.dec_value;
          idx_next           = idx + nva_pkg::CNT_W'(1);
        end else begin
          state_next = nva_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = nva_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nva_pkg::ST_IDLE;
      fc        <= nva_pkg::VOICE_COUNT_C;
      pc        <= '0;
      rc        <= '0;
      have_pend <= 1'b0;
      for (int i = 0; i < nva_pkg::VOICE_COUNT; i++) begin
        free_stack[i] <= nva_pkg::IDX_W'(nva_pkg::VOICE_COUNT - 1 - i);
      end
    end else begin
      state      <= state_next;
      fc         <= fc_next;
      pc         <= pc_next;
      rc         <= rc_next;
      have_pend  <= have_pend_next;
      free_stack <= free_stack_next;
    end
  end

  // datapath registers and voice stores
  always_ff @(posedge clk) begin
    if (accept) begin
      len_r   <= req.note_length;
      pitch_r <= req.pitch_value;
      duty_r  <= req.duty_value;
      att_r   <= req.attack_volume;
      dec_r   <= req.decay_volume;
      wave_r  <= req.wave_and_release;
      pan_r   <= req.stereo_pan;
    end
    rem        <= rem_next;
    vpan       <= vpan_next;
    order      <= order_next;
    rel_stack  <= rel_stack_next;
    pos        <= pos_next;
    head       <= head_next;
    idx        <= idx_next;
    cur_voice  <= cur_voice_next;
    pend_voice <= pend_voice_next;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // one request as the sender holds it
  typedef struct {
    logic              operation;
    logic [15:0]       note_length;
    logic [15:0]       pitch_value;
    logic [15:0]       duty_value;
    logic [7:0]        attack_volume;
    logic [7:0]        decay_volume;
    logic [7:0]        wave_and_release;
    logic signed [7:0] stereo_pan;
  } note_req_t;

  // voice pool tracker: follows the allocator and queues the register writes it should make
  class voice_write_tracker;
    logic [15:0]      ticks_left [nva_pkg::VOICE_COUNT];
    logic [7:0]       pan_byte [nva_pkg::VOICE_COUNT];
    nva_pkg::voice_t  sorted_voices [nva_pkg::VOICE_COUNT];
    int unsigned      active_cnt;
    nva_pkg::voice_t  idle_stack [nva_pkg::VOICE_COUNT];
    int unsigned      idle_cnt;
    nva_pkg::voice_t  freed_stack [nva_pkg::VOICE_COUNT];
    int unsigned      freed_cnt;
    nva_pkg::result_t expected_writes [$];
    int               mismatches;

    function new();
      int i;
      for (i = 0; i < nva_pkg::VOICE_COUNT; i++) begin
        ticks_left[i]    = '0;
        pan_byte[i]      = '0;
        sorted_voices[i] = '0;
        freed_stack[i]   = '0;
        idle_stack[i]    = nva_pkg::voice_t'(nva_pkg::VOICE_COUNT - 1 - i);
      end
      idle_cnt   = nva_pkg::VOICE_COUNT;
      active_cnt = 0;
      freed_cnt  = 0;
      mismatches = 0;
    endfunction

    // advance the pool for one accepted request
    function void accept_request(note_req_t rq);
      nva_pkg::result_t w;
      nva_pkg::voice_t  v;
      int unsigned      pos;
      int unsigned      n_rel;
      int               i;
      w = '0;
      if (rq.operation == nva_pkg::OP_PLAY) begin
        // pool exhausted: error write, nothing changes
        if (idle_cnt == 0 || active_cnt >= nva_pkg::VOICE_COUNT) begin
          w.no_voice_error = 1'b1;
          w.last_of_run    = 1'b1;
          expected_writes.push_back(w);
          return;
        end
        idle_cnt--;
        v = idle_stack[idle_cnt];
        ticks_left[v] = rq.note_length;
        pan_byte[v]   = rq.stereo_pan;
        // sorted insert ahead of the first equal or longer note
        pos = 0;
        while (pos < active_cnt && rq.note_length > ticks_left[sorted_voices[pos]])
          pos++;
        for (i = active_cnt; i > pos; i--)
          sorted_voices[i] = sorted_voices[i-1];
        sorted_voices[pos] = v;
        active_cnt++;
        w.voice_index   = v;
        w.gate_on       = 1'b1;
        w.out_pitch     = rq.pitch_value;
        w.out_duty      = rq.duty_value;
        w.out_attack    = rq.attack_volume;
        w.out_decay     = rq.decay_volume;
        w.out_wave      = rq.wave_and_release;
        w.pan_gate_byte = pan_byte[v] | nva_pkg::PAN_ON_BIT;
        w.last_of_run   = 1'b1;
        expected_writes.push_back(w);
        return;
      end

      // last tick's releases go back, most recent first
      while (freed_cnt > 0 && idle_cnt < nva_pkg::VOICE_COUNT) begin
        freed_cnt--;
        idle_stack[idle_cnt] = freed_stack[freed_cnt];
        idle_cnt++;
      end
      freed_cnt = 0;

      // count the expiring voices at the head
      n_rel = 0;
      while (n_rel < active_cnt && n_rel < nva_pkg::MAX_RESULTS &&
             ticks_left[sorted_voices[n_rel]] <= 16'd1)
        n_rel++;

      // gate-off writes for them
      for (i = 0; i < n_rel; i++) begin
        v = sorted_voices[i];
        if (freed_cnt < nva_pkg::VOICE_COUNT) begin
          freed_stack[freed_cnt] = v;
          freed_cnt++;
        end
        w = '0;
        w.voice_index   = v;
        w.pan_gate_byte = pan_byte[v] & nva_pkg::PAN_OFF_MASK;
        w.last_of_run   = (i == n_rel - 1);
        expected_writes.push_back(w);
      end
      for (i = n_rel; i < active_cnt; i++)
        sorted_voices[i - n_rel] = sorted_voices[i];
      active_cnt -= n_rel;

      // count down the voices still sounding
      for (i = 0; i < active_cnt; i++) begin
        v = sorted_voices[i];
        if (ticks_left[v] != 16'd0)
          ticks_left[v] = ticks_left[v] - 16'd1;
      end
    endfunction

    function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (exp_val !== act_val) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    // match one write transfer against the oldest expected write
    function void check_write(nva_pkg::result_t got);
      nva_pkg::result_t e;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual voice %0d gate %0b err %0b",
                 $time, got.voice_index, got.gate_on, got.no_voice_error);
        mismatches++;
        return;
      end
      e = expected_writes.pop_front();
      compare_field("voice_index", 16'(e.voice_index), 16'(got.voice_index));
      compare_field("gate_on", 16'(e.gate_on), 16'(got.gate_on));
      compare_field("out_pitch", e.out_pitch, got.out_pitch);
      compare_field("out_duty", e.out_duty, got.out_duty);
      compare_field("out_attack", 16'(e.out_attack), 16'(got.out_attack));
      compare_field("out_decay", 16'(e.out_decay), 16'(got.out_decay));
      compare_field("out_wave", 16'(e.out_wave), 16'(got.out_wave));
      compare_field("pan_gate_byte", 16'(e.pan_gate_byte), 16'(got.pan_gate_byte));
      compare_field("no_voice_error", 16'(e.no_voice_error), 16'(got.no_voice_error));
      compare_field("last_of_run", 16'(e.last_of_run), 16'(got.last_of_run));
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   no_idle;

  nva_req_if req_ch ();
  nva_rsp_if rsp_ch ();

  voice_write_tracker tracker = new();

  note_voice_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic note_req_t make_play(logic [15:0] len, logic [15:0] pitch,
                                          logic [15:0] duty, logic [7:0] att,
                                          logic [7:0] dec, logic [7:0] wave,
                                          logic [7:0] pan);
    note_req_t rq;
    rq.operation        = nva_pkg::OP_PLAY;
    rq.note_length      = len;
    rq.pitch_value      = pitch;
    rq.duty_value       = duty;
    rq.attack_volume    = att;
    rq.decay_volume     = dec;
    rq.wave_and_release = wave;
    rq.stereo_pan       = pan;
    return rq;
  endfunction

  function automatic note_req_t random_play(logic [15:0] len);
    return make_play(len, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
  endfunction

  // ticks carry random payload that the block ignores
  function automatic note_req_t random_tick();
    note_req_t rq;
    rq = random_play(16'($urandom));
    rq.operation = nva_pkg::OP_TICK;
    return rq;
  endfunction

  // mostly short notes so voices keep cycling
  function automatic logic [15:0] random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 16'($urandom_range(0, 6));
    if (r < 95)
      return 16'($urandom_range(7, 20));
    return 16'($urandom_range(21, 60));
  endfunction

  // one request transfer, after a random gap
  task automatic send_request(note_req_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.operation        <= rq.operation;
    req_ch.note_length      <= rq.note_length;
    req_ch.pitch_value      <= rq.pitch_value;
    req_ch.duty_value       <= rq.duty_value;
    req_ch.attack_volume    <= rq.attack_volume;
    req_ch.decay_volume     <= rq.decay_volume;
    req_ch.wave_and_release <= rq.wave_and_release;
    req_ch.stereo_pan       <= rq.stereo_pan;
    do @(posedge clk); while (!req_ch.ready);
    tracker.accept_request(rq);
  endtask

  task automatic send_ticks(int count);
    int i;
    for (i = 0; i < count; i++)
      send_request(random_tick());
  endtask

  task automatic drain_writes();
    req_ch.valid <= 1'b0;
    while (tracker.expected_writes.size() != 0) @(posedge clk);
  endtask

  // result side: random ready, check every write transfer
  initial begin : result_sink
    int               hold;
    int               g;
    nva_pkg::result_t got;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.voice_index    = rsp_ch.voice_index;
        got.gate_on        = rsp_ch.gate_on;
        got.out_pitch      = rsp_ch.out_pitch;
        got.out_duty       = rsp_ch.out_duty;
        got.out_attack     = rsp_ch.out_attack;
        got.out_decay      = rsp_ch.out_decay;
        got.out_wave       = rsp_ch.out_wave;
        got.pan_gate_byte  = rsp_ch.pan_gate_byte;
        got.no_voice_error = rsp_ch.no_voice_error;
        got.last_of_run    = rsp_ch.last_of_run;
        tracker.check_write(got);
      end
      if (hold > 0) begin
        hold--;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          rsp_ch.ready <= 1'b1;
          hold = $urandom_range(0, 6);
        end else begin
          rsp_ch.ready <= 1'b0;
          hold = g - 1;
        end
      end
    end
  end

  // run limit
  initial begin
    #10000000;
    $display("testbench NOT OK");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int i;
    int r;
    no_idle = 1'b0;
    rst <= 1'b1;
    req_ch.valid            <= 1'b0;
    req_ch.operation        <= nva_pkg::OP_PLAY;
    req_ch.note_length      <= '0;
    req_ch.pitch_value      <= '0;
    req_ch.duty_value       <= '0;
    req_ch.attack_volume    <= '0;
    req_ch.decay_volume     <= '0;
    req_ch.wave_and_release <= '0;
    req_ch.stereo_pan       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tick with nothing playing gives no writes
    send_request(random_tick());
    // zero length note, all-zero fields, most negative pan
    send_request(make_play(16'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h80));
    // longest note, all-ones fields, most positive pan
    send_request(make_play(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F));
    // equal lengths go ahead of the existing one
    send_request(make_play(16'd3, 16'h1234, 16'hABCD, 8'h5A, 8'hA5, 8'h3C, 8'hFF));
    send_request(random_play(16'd3));
    send_request(random_play(16'd1));
    send_request(random_play(16'd2));
    send_request(random_play(16'd5));
    send_request(random_play(16'd4));
    // pool full: refused
    send_request(random_play(16'd2));
    send_request(random_tick());
    // releases stay out of the pool until the next tick
    send_request(random_play(16'd1));
    send_request(random_tick());
    send_request(random_play(16'd0));
    send_ticks(4);
    send_request(random_play(16'd1));
    send_request(random_play(16'd1));
    send_request(random_play(16'd0));
    send_ticks(3);

    // hold off until every write is out
    drain_writes();
    repeat (20) @(posedge clk);

    // random traffic, with some stretches at full rate
    for (i = 0; i < 350; i++) begin
      if (i % 70 == 0)
        no_idle = 1'b1;
      else if (i % 70 == 25)
        no_idle = 1'b0;
      if (i == 175) begin
        drain_writes();
        repeat (20) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 55)
        send_request(random_play(random_length()));
      else
        send_request(random_tick());
    end
    no_idle = 1'b0;
    req_ch.valid <= 1'b0;

    // let the last writes come out
    while (tracker.expected_writes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
